// File: rtl/core/pmo_pkg.sv
// shared types and arithmetic helpers for the premultiplied rgba over i420 blender
// no dependencies; used by the pipeline modules under rtl/core
package pmo_pkg;

   typedef struct packed {
      logic [7:0] b;
      logic [7:0] g;
      logic [7:0] r;
   } rgb_type;

   // destination values carried along for the all-transparent bypass
   typedef struct packed {
      logic [3:0][7:0] luma;
      logic [7:0]      cb;
      logic [7:0]      cr;
      logic            untouched;
   } pass_type;

   typedef struct packed {
      logic [3:0][31:0] src;
      logic [3:0][7:0]  luma;
      logic [7:0]       cb;
      logic [7:0]       cr;
   } req_type;

   typedef struct packed {
      pass_type         pass;
      logic [3:0][31:0] src;
      rgb_type [3:0]    dst;
   } conv_type;

   typedef struct packed {
      pass_type               pass;
      rgb_type [3:0]          src;
      logic [3:0][2:0][15:0]  prod;
   } prod_type;

   typedef struct packed {
      pass_type      pass;
      rgb_type [3:0] mix;
   } mix_type;

   typedef struct packed {
      pass_type        pass;
      logic [3:0][7:0] y_new;
      rgb_type         avg;
   } luma_type;

   typedef struct packed {
      logic [3:0][7:0] luma;
      logic [7:0]      cb;
      logic [7:0]      cr;
      logic            untouched;
   } rsp_type;

   localparam int unsigned PixCount = 4;

   function automatic logic [7:0] sat8(input logic signed [19:0] v);
      logic [7:0] res;
      if (v < 20'sd0) begin
         res = 8'd0;
      end else if (v > 20'sd255) begin
         res = 8'd255;
      end else begin
         res = v[7:0];
      end
      return res;
   endfunction

   // bt.601 limited range to rgb, floor shift by 256
   function automatic rgb_type ycc_to_rgb(input logic [7:0] y, input logic [7:0] cb,
                                          input logic [7:0] cr);
      logic signed [9:0]  c;
      logic signed [9:0]  d;
      logic signed [9:0]  e;
      logic signed [19:0] rs;
      logic signed [19:0] gs;
      logic signed [19:0] bs;
      rgb_type            res;
      c  = $signed({2'b00, y}) - 10'sd16;
      d  = $signed({2'b00, cb}) - 10'sd128;
      e  = $signed({2'b00, cr}) - 10'sd128;
      rs = 20'sd298 * c + 20'sd409 * e + 20'sd128;
      gs = 20'sd298 * c - 20'sd100 * d - 20'sd208 * e + 20'sd128;
      bs = 20'sd298 * c + 20'sd516 * d + 20'sd128;
      res.r = sat8(rs >>> 8);
      res.g = sat8(gs >>> 8);
      res.b = sat8(bs >>> 8);
      return res;
   endfunction

   // src + round(p / 255), saturated; (v + 1 + v/256) / 256 equals v / 255 for v below 65280
   function automatic logic [7:0] blend_round(input logic [15:0] p, input logic [7:0] s);
      logic [16:0] v;
      logic [16:0] w;
      logic [8:0]  t;
      v = {1'b0, p} + 17'd127;
      w = v + 17'd1 + {8'd0, v[16:8]};
      t = {1'b0, s} + {1'b0, w[15:8]};
      return t[8] ? 8'hFF : t[7:0];
   endfunction

   function automatic logic [7:0] luma_of(input rgb_type c);
      logic [17:0] acc;
      logic [9:0]  y;
      acc = 18'd66 * {10'd0, c.r} + 18'd129 * {10'd0, c.g} + 18'd25 * {10'd0, c.b}
            + 18'd128;
      y   = acc[17:8] + 10'd16;
      return (y > 10'd255) ? 8'hFF : y[7:0];
   endfunction

   function automatic logic [7:0] cb_of(input rgb_type c);
      logic signed [19:0] acc;
      acc = 20'sd112 * $signed({12'd0, c.b}) - 20'sd38 * $signed({12'd0, c.r})
            - 20'sd74 * $signed({12'd0, c.g}) + 20'sd128;
      return sat8((acc >>> 8) + 20'sd128);
   endfunction

   function automatic logic [7:0] cr_of(input rgb_type c);
      logic signed [19:0] acc;
      acc = 20'sd112 * $signed({12'd0, c.r}) - 20'sd94 * $signed({12'd0, c.g})
            - 20'sd18 * $signed({12'd0, c.b}) + 20'sd128;
      return sat8((acc >>> 8) + 20'sd128);
   endfunction

   function automatic logic [7:0] avg4(input logic [7:0] a, input logic [7:0] b,
                                       input logic [7:0] c, input logic [7:0] d);
      logic [9:0] s;
      s = {2'b00, a} + {2'b00, b} + {2'b00, c} + {2'b00, d} + 10'd2;
      return s[9:2];
   endfunction

endpackage

// File: rtl/core/pmo_ycc2rgb.sv
// stage 1: destination yuv to rgb for the four pixels, plus transparency detect
// depends on pmo_pkg
module pmo_ycc2rgb (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  pmo_pkg::req_type   in_data,
   output logic               out_valid,
   input  logic               out_ready,
   output pmo_pkg::conv_type  out_data
);
   import pmo_pkg::*;

   logic     s1_vld_ff;
   logic     s1_vld_in;
   conv_type s1_data_ff;
   conv_type s1_data_in;

   always_comb begin
      logic alpha_any;
      alpha_any = 1'b0;
      for (int i = 0; i < PixCount; i++) begin
         alpha_any = alpha_any | (|in_data.src[i][31:24]);
         s1_data_in.dst[i] = ycc_to_rgb(in_data.luma[i], in_data.cb, in_data.cr);
      end
      s1_data_in.src            = in_data.src;
      s1_data_in.pass.luma      = in_data.luma;
      s1_data_in.pass.cb        = in_data.cb;
      s1_data_in.pass.cr        = in_data.cr;
      s1_data_in.pass.untouched = !alpha_any;
   end

   assign in_ready  = !s1_vld_ff || out_ready;
   assign s1_vld_in = in_ready ? in_valid : s1_vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff <= s1_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         s1_data_ff <= s1_data_in;
      end
   end

   assign out_valid = s1_vld_ff;
   assign out_data  = s1_data_ff;

endmodule

// File: rtl/core/pmo_blend.sv
// stages 2 and 3: dst*(255-a) products, then rounding divide by 255 and saturating add
// depends on pmo_pkg
module pmo_blend (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  pmo_pkg::conv_type  in_data,
   output logic               out_valid,
   input  logic               out_ready,
   output pmo_pkg::mix_type   out_data
);
   import pmo_pkg::*;

   logic     s2_vld_ff;
   logic     s2_vld_in;
   logic     s2_ready;
   prod_type s2_data_ff;
   prod_type s2_data_in;
   logic     s3_vld_ff;
   logic     s3_vld_in;
   mix_type  s3_data_ff;
   mix_type  s3_data_in;

   always_comb begin
      logic [7:0] inv;
      for (int i = 0; i < PixCount; i++) begin
         inv = 8'd255 - in_data.src[i][31:24];
         s2_data_in.src[i].r  = in_data.src[i][7:0];
         s2_data_in.src[i].g  = in_data.src[i][15:8];
         s2_data_in.src[i].b  = in_data.src[i][23:16];
         s2_data_in.prod[i][0] = {8'd0, in_data.dst[i].r} * {8'd0, inv};
         s2_data_in.prod[i][1] = {8'd0, in_data.dst[i].g} * {8'd0, inv};
         s2_data_in.prod[i][2] = {8'd0, in_data.dst[i].b} * {8'd0, inv};
      end
      s2_data_in.pass = in_data.pass;
   end

   always_comb begin
      for (int i = 0; i < PixCount; i++) begin
         s3_data_in.mix[i].r = blend_round(s2_data_ff.prod[i][0], s2_data_ff.src[i].r);
         s3_data_in.mix[i].g = blend_round(s2_data_ff.prod[i][1], s2_data_ff.src[i].g);
         s3_data_in.mix[i].b = blend_round(s2_data_ff.prod[i][2], s2_data_ff.src[i].b);
      end
      s3_data_in.pass = s2_data_ff.pass;
   end

   assign s2_ready  = !s3_vld_ff || out_ready;
   assign in_ready  = !s2_vld_ff || s2_ready;
   assign s2_vld_in = in_ready ? in_valid : s2_vld_ff;
   assign s3_vld_in = s2_ready ? s2_vld_ff : s3_vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_vld_ff <= 1'b0;
         s3_vld_ff <= 1'b0;
      end else begin
         s2_vld_ff <= s2_vld_in;
         s3_vld_ff <= s3_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         s2_data_ff <= s2_data_in;
      end
      if (s2_vld_ff && s2_ready) begin
         s3_data_ff <= s3_data_in;
      end
   end

   assign out_valid = s3_vld_ff;
   assign out_data  = s3_data_ff;

endmodule

// File: rtl/core/pmo_rgb2ycc.sv
// stages 4 and 5: per-pixel luma and block rgb average, then chroma and bypass select
// depends on pmo_pkg; stage 5 is the output register
module pmo_rgb2ycc (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  pmo_pkg::mix_type  in_data,
   output logic              out_valid,
   input  logic              out_ready,
   output pmo_pkg::rsp_type  out_data
);
   import pmo_pkg::*;

   logic     s4_vld_ff;
   logic     s4_vld_in;
   logic     s4_ready;
   luma_type s4_data_ff;
   luma_type s4_data_in;
   logic     s5_vld_ff;
   logic     s5_vld_in;
   rsp_type  s5_data_ff;
   rsp_type  s5_data_in;

   always_comb begin
      for (int i = 0; i < PixCount; i++) begin
         s4_data_in.y_new[i] = luma_of(in_data.mix[i]);
      end
      s4_data_in.avg.r = avg4(in_data.mix[0].r, in_data.mix[1].r,
                              in_data.mix[2].r, in_data.mix[3].r);
      s4_data_in.avg.g = avg4(in_data.mix[0].g, in_data.mix[1].g,
                              in_data.mix[2].g, in_data.mix[3].g);
      s4_data_in.avg.b = avg4(in_data.mix[0].b, in_data.mix[1].b,
                              in_data.mix[2].b, in_data.mix[3].b);
      s4_data_in.pass  = in_data.pass;
   end

   // fully transparent block keeps the destination exactly
   always_comb begin
      s5_data_in.untouched = s4_data_ff.pass.untouched;
      if (s4_data_ff.pass.untouched) begin
         s5_data_in.luma = s4_data_ff.pass.luma;
         s5_data_in.cb   = s4_data_ff.pass.cb;
         s5_data_in.cr   = s4_data_ff.pass.cr;
      end else begin
         s5_data_in.luma = s4_data_ff.y_new;
         s5_data_in.cb   = cb_of(s4_data_ff.avg);
         s5_data_in.cr   = cr_of(s4_data_ff.avg);
      end
   end

   assign s4_ready  = !s5_vld_ff || out_ready;
   assign in_ready  = !s4_vld_ff || s4_ready;
   assign s4_vld_in = in_ready ? in_valid : s4_vld_ff;
   assign s5_vld_in = s4_ready ? s4_vld_ff : s5_vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_vld_ff <= 1'b0;
         s5_vld_ff <= 1'b0;
      end else begin
         s4_vld_ff <= s4_vld_in;
         s5_vld_ff <= s5_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         s4_data_ff <= s4_data_in;
      end
      if (s4_vld_ff && s4_ready) begin
         s5_data_ff <= s5_data_in;
      end
   end

   assign out_valid = s5_vld_ff;
   assign out_data  = s5_data_ff;

endmodule

// File: rtl/core/premul_rgba_over_i420_block.sv
// top level of the premultiplied rgba over i420 blender
// depends on pmo_pkg, pmo_ycc2rgb, pmo_blend, pmo_rgb2ycc
//
// Takes one 2x2 block word per clock while req_ready is high and returns one result word
// per block, in order. Between acceptance and rsp_valid come inverse color conversion,
// blend products, rounding divide and saturate, per-pixel luma with block average, and
// chroma with the output register. Each of the five register stages holds its own valid
// bit and fills a bubble even while later stages are stalled, so req_ready drops only
// when all five stages hold a word and rsp_ready is low. A block whose four alphas are
// all zero returns its destination samples unchanged with rsp_block_untouched set.
module premul_rgba_over_i420_block (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [31:0] req_src_pixel_00,
   input  logic [31:0] req_src_pixel_01,
   input  logic [31:0] req_src_pixel_10,
   input  logic [31:0] req_src_pixel_11,
   input  logic [7:0]  req_dst_luma_00,
   input  logic [7:0]  req_dst_luma_01,
   input  logic [7:0]  req_dst_luma_10,
   input  logic [7:0]  req_dst_luma_11,
   input  logic [7:0]  req_dst_cb,
   input  logic [7:0]  req_dst_cr,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_out_luma_00,
   output logic [7:0]  rsp_out_luma_01,
   output logic [7:0]  rsp_out_luma_10,
   output logic [7:0]  rsp_out_luma_11,
   output logic [7:0]  rsp_out_cb,
   output logic [7:0]  rsp_out_cr,
   output logic        rsp_block_untouched
);
   import pmo_pkg::*;

   req_type  req_data;
   conv_type conv_data;
   mix_type  mix_data;
   rsp_type  rsp_data;
   logic     conv_valid;
   logic     conv_ready;
   logic     mix_valid;
   logic     mix_ready;

   always_comb begin
      req_data.src[0]  = req_src_pixel_00;
      req_data.src[1]  = req_src_pixel_01;
      req_data.src[2]  = req_src_pixel_10;
      req_data.src[3]  = req_src_pixel_11;
      req_data.luma[0] = req_dst_luma_00;
      req_data.luma[1] = req_dst_luma_01;
      req_data.luma[2] = req_dst_luma_10;
      req_data.luma[3] = req_dst_luma_11;
      req_data.cb      = req_dst_cb;
      req_data.cr      = req_dst_cr;
   end

   pmo_ycc2rgb u_ycc2rgb (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_data   (req_data),
      .out_valid (conv_valid),
      .out_ready (conv_ready),
      .out_data  (conv_data)
   );

   pmo_blend u_blend (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (conv_valid),
      .in_ready  (conv_ready),
      .in_data   (conv_data),
      .out_valid (mix_valid),
      .out_ready (mix_ready),
      .out_data  (mix_data)
   );

   pmo_rgb2ycc u_rgb2ycc (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (mix_valid),
      .in_ready  (mix_ready),
      .in_data   (mix_data),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_data  (rsp_data)
   );

   assign rsp_out_luma_00     = rsp_data.luma[0];
   assign rsp_out_luma_01     = rsp_data.luma[1];
   assign rsp_out_luma_10     = rsp_data.luma[2];
   assign rsp_out_luma_11     = rsp_data.luma[3];
   assign rsp_out_cb          = rsp_data.cb;
   assign rsp_out_cr          = rsp_data.cr;
   assign rsp_block_untouched = rsp_data.untouched;

endmodule

// File: rtl/core/pmo_checker.sv
// port-level checks for premul_rgba_over_i420_block, attached by bind
// no package dependencies
module pmo_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_out_luma_00,
   input logic [7:0] rsp_out_luma_01,
   input logic [7:0] rsp_out_luma_10,
   input logic [7:0] rsp_out_luma_11,
   input logic [7:0] rsp_out_cb,
   input logic [7:0] rsp_out_cr,
   input logic       rsp_block_untouched
);

   // a result word stays offered until taken
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp_valid dropped before rsp_ready");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_out_luma_00) && $stable(rsp_out_luma_01)
         && $stable(rsp_out_luma_10) && $stable(rsp_out_luma_11) && $stable(rsp_out_cb)
         && $stable(rsp_out_cr) && $stable(rsp_block_untouched))
      else $error("rsp word changed while stalled");

   // input back-pressure only when every stage is full and the output is stalled
   assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("req_ready low with room in the pipeline");

   // with the output drained every cycle, an accepted word passes straight through to rsp_valid
   assert property (@(posedge clock) disable iff (reset)
      $past(req_valid && req_ready, 5) && !$past(reset, 1) && !$past(reset, 2)
         && !$past(reset, 3) && !$past(reset, 4) && !$past(reset, 5)
         && $past(rsp_ready, 1) && $past(rsp_ready, 2) && $past(rsp_ready, 3)
         && $past(rsp_ready, 4)
      |-> rsp_valid)
      else $error("accepted block did not reach the output in five cycles");

endmodule

bind premul_rgba_over_i420_block pmo_checker u_pmo_checker (.*);

// File: sim/tb.sv
// self-checking bench for premul_rgba_over_i420_block: premultiplied rgba 2x2 blocks
// blended over bt.601 i420 samples, checked in order against an in-bench predictor
// depends on rtl/core/premul_rgba_over_i420_block.sv and its submodules only
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CycleLimit  = 200000;
   localparam int RandomCount = 450;
   localparam int HoldCycles  = 300;

   typedef struct packed {
      bit [3:0][31:0] src;
      bit [3:0][7:0]  luma;
      bit [7:0]       cb;
      bit [7:0]       cr;
   } block_type;

   typedef struct packed {
      logic [3:0][7:0] luma;
      logic [7:0]      cb;
      logic [7:0]      cr;
      logic            untouched;
   } blended_type;

   class blend_scoreboard;
      blended_type pending[$];
      int          errors = 0;

      function int clip8(int v);
         return (v < 0) ? 0 : ((v > 255) ? 255 : v);
      endfunction

      // composite the source block over the destination and convert back to i420
      function blended_type blend_over(block_type b);
         blended_type res;
         bit [7:0]    alpha_any;
         int          c, d, e, inv, t;
         int          dst[3];
         int          mix[3];
         int          sum[3];
         alpha_any = '0;
         for (int i = 0; i < 4; i++) alpha_any |= b.src[i][31:24];
         if (alpha_any == 0) begin
            res.luma      = b.luma;
            res.cb        = b.cb;
            res.cr        = b.cr;
            res.untouched = 1'b1;
            return res;
         end
         sum = '{0, 0, 0};
         d = int'(b.cb) - 128;
         e = int'(b.cr) - 128;
         for (int i = 0; i < 4; i++) begin
            c = int'(b.luma[i]) - 16;
            dst[0] = clip8((298 * c + 409 * e + 128) >>> 8);
            dst[1] = clip8((298 * c - 100 * d - 208 * e + 128) >>> 8);
            dst[2] = clip8((298 * c + 516 * d + 128) >>> 8);
            inv = 255 - int'(b.src[i][31:24]);
            for (int k = 0; k < 3; k++) begin
               t = int'(b.src[i][8*k +: 8]) + (dst[k] * inv + 127) / 255;
               mix[k] = (t > 255) ? 255 : t;
               sum[k] += mix[k];
            end
            res.luma[i] = 8'(clip8(((66 * mix[0] + 129 * mix[1] + 25 * mix[2] + 128) >>> 8)
                                   + 16));
         end
         for (int k = 0; k < 3; k++) sum[k] = (sum[k] + 2) >>> 2;
         res.cb = 8'(clip8(((-38 * sum[0] - 74 * sum[1] + 112 * sum[2] + 128) >>> 8) + 128));
         res.cr = 8'(clip8(((112 * sum[0] - 94 * sum[1] - 18 * sum[2] + 128) >>> 8) + 128));
         res.untouched = 1'b0;
         return res;
      endfunction

      function void note_block(block_type b);
         pending.push_back(blend_over(b));
      endfunction

      function void compare(string field, logic [7:0] want, logic [7:0] got);
         if (got !== want) begin
            $display("%0t: %s mismatch: expected %0d, got %0d", $time, field, want, got);
            errors++;
         end
      endfunction

      function void check_result(blended_type got);
         blended_type want;
         if (pending.size() == 0) begin
            $display("%0t: result word with none expected: %h", $time, got);
            errors++;
            return;
         end
         want = pending.pop_front();
         for (int i = 0; i < 4; i++)
            compare($sformatf("luma_%0d%0d", i / 2, i % 2), want.luma[i], got.luma[i]);
         compare("cb", want.cb, got.cb);
         compare("cr", want.cr, got.cr);
         compare("untouched", 8'(want.untouched), 8'(got.untouched));
      endfunction

      function void close_out();
         if (pending.size() != 0) begin
            $display("%0t: %0d result words never arrived", $time, pending.size());
            errors += pending.size();
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   block_type   req_word = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   blended_type rsp_word;

   logic [7:0] out_luma_00, out_luma_01, out_luma_10, out_luma_11, out_cb, out_cr;
   logic       out_untouched;

   int  send_idle = 0;
   int  recv_idle = 0;
   bit  hold_request = 1'b0;
   int  hold_left = 0;
   int  cycles = 0;
   blend_scoreboard sb;

   always #5 clock = ~clock;

   premul_rgba_over_i420_block u_top (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_src_pixel_00    (req_word.src[0]),
      .req_src_pixel_01    (req_word.src[1]),
      .req_src_pixel_10    (req_word.src[2]),
      .req_src_pixel_11    (req_word.src[3]),
      .req_dst_luma_00     (req_word.luma[0]),
      .req_dst_luma_01     (req_word.luma[1]),
      .req_dst_luma_10     (req_word.luma[2]),
      .req_dst_luma_11     (req_word.luma[3]),
      .req_dst_cb          (req_word.cb),
      .req_dst_cr          (req_word.cr),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_out_luma_00     (out_luma_00),
      .rsp_out_luma_01     (out_luma_01),
      .rsp_out_luma_10     (out_luma_10),
      .rsp_out_luma_11     (out_luma_11),
      .rsp_out_cb          (out_cb),
      .rsp_out_cr          (out_cr),
      .rsp_block_untouched (out_untouched)
   );

   assign rsp_word = {out_luma_11, out_luma_10, out_luma_01, out_luma_00, out_cb, out_cr,
                      out_untouched};

   // receiver: random stalls, or a long hold-off counted here
   always @(negedge clock) begin
      if (hold_request) begin
         hold_request = 1'b0;
         hold_left    = HoldCycles;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready = 1'b0;
      end else begin
         rsp_ready = ($urandom_range(99) >= recv_idle);
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) sb.note_block(req_word);
         if (rsp_valid && rsp_ready) sb.check_result(rsp_word);
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CycleLimit) begin
         $display("tb: errors");
         $finish;
      end
   end

   function automatic bit [31:0] rand_pixel();
      bit [31:0] p;
      p = $urandom();
      case ($urandom_range(4))
         0: p[31:24] = 8'h00;
         1: p[31:24] = 8'hFF;
         2: begin
            // well-formed premultiplication: no channel above alpha
            for (int k = 0; k < 3; k++) p[8*k +: 8] = 8'($urandom_range(p[31:24]));
         end
         default: ;
      endcase
      return p;
   endfunction

   function automatic block_type rand_block();
      block_type b;
      for (int i = 0; i < 4; i++) begin
         b.src[i]  = rand_pixel();
         b.luma[i] = 8'($urandom_range(255));
      end
      b.cb = 8'($urandom_range(255));
      b.cr = 8'($urandom_range(255));
      if ($urandom_range(9) == 0)
         for (int i = 0; i < 4; i++) b.src[i][31:24] = 8'h00;
      return b;
   endfunction

   // valid stays high across back-to-back words, dropped only while idling
   task automatic send_block(input block_type b);
      @(negedge clock);
      while ($urandom_range(99) < send_idle) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_word  = b;
      req_valid = 1'b1;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic send_uniform(input bit [31:0] pix, input bit [7:0] y, input bit [7:0] cb,
                               input bit [7:0] cr);
      block_type b;
      b.src  = {4{pix}};
      b.luma = {4{y}};
      b.cb   = cb;
      b.cr   = cr;
      send_block(b);
   endtask

   task automatic drain();
      @(negedge clock);
      req_valid = 1'b0;
      do @(negedge clock); while (sb.pending.size() != 0);
   endtask

   task automatic set_idling(input int s, input int r);
      @(posedge clock);
      send_idle = s;
      recv_idle = r;
   endtask

   initial begin
      block_type b;
      sb = new();
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      set_idling(16, 87);
      // transparent blocks pass through, even with nonzero color bits
      send_uniform(32'h0000_0000, 8'd0, 8'd0, 8'd0);
      send_uniform(32'h00FF_FFFF, 8'd255, 8'd255, 8'd255);
      // opaque extremes, single channels and one half-alpha grey
      send_uniform(32'hFF00_0000, 8'd128, 8'd128, 8'd128);
      send_uniform(32'hFFFF_FFFF, 8'd16, 8'd128, 8'd128);
      send_uniform(32'hFF00_00FF, 8'd235, 8'd16, 8'd240);
      send_uniform(32'hFF00_FF00, 8'd0, 8'd255, 8'd0);
      send_uniform(32'hFFFF_0000, 8'd255, 8'd0, 8'd255);
      send_uniform(32'h8040_4040, 8'd100, 8'd90, 8'd200);
      // channel above alpha saturates the sum, then near-transparent and partial-alpha blocks
      send_uniform(32'h01FF_FFFF, 8'd235, 8'd128, 8'd128);
      send_uniform(32'h7FFF_80FF, 8'd255, 8'd255, 8'd255);
      send_uniform(32'h0100_0000, 8'd255, 8'd0, 8'd255);
      send_uniform(32'h0100_0000, 8'd0, 8'd255, 8'd0);
      for (int i = 0; i < 4; i++)
         send_uniform(32'hC010_2030, 8'(i * 85), (i & 1) ? 8'd255 : 8'd0,
                      (i & 2) ? 8'd255 : 8'd0);
      // only one pixel carries alpha
      b        = '0;
      b.src[2] = 32'h7F7F_7F7F;
      b.luma   = {8'd235, 8'd16, 8'd255, 8'd0};
      b.cb     = 8'd60;
      b.cr     = 8'd190;
      send_block(b);
      // only one pixel fully transparent
      b.src    = {32'hFE10_F0FE, 32'h0000_0000, 32'hFFFF_FFFF, 32'h5555_AAAA};
      b.luma   = {8'd0, 8'd255, 8'd0, 8'd255};
      b.cb     = 8'd255;
      b.cr     = 8'd0;
      send_block(b);
      for (int n = 0; n < RandomCount; n++) send_block(rand_block());
      drain();

      set_idling(87, 16);
      for (int n = 0; n < RandomCount; n++) send_block(rand_block());
      drain();

      set_idling(0, 0);
      hold_request = 1'b1;
      for (int n = 0; n < RandomCount; n++) send_block(rand_block());
      drain();

      repeat (20) @(posedge clock);
      sb.close_out();
      if (sb.errors == 0) begin
         $display("tb: clean");
      end else begin
         $display("tb: errors");
      end
      $finish;
   end

endmodule
